FILE: rtl/core/sogs_pkg.sv
package sogs_pkg;

    localparam int SINE_ADDR_BITS = 10;
    localparam int TANH_ADDR_BITS = 8;
    localparam int SINE_LEN       = 1 << SINE_ADDR_BITS;
    localparam int TANH_LEN       = (1 << TANH_ADDR_BITS) + 1;
    localparam int TANH_FB        = 30 - TANH_ADDR_BITS;

    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = TANH_FB + 2;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [31:0] PHASE_STEP_RST = 32'd39370534;
    localparam logic [15:0] TARGET_RST     = 16'd6554;
    localparam logic [15:0] ALPHA_RST      = 16'd131;
    localparam logic [15:0] GAIN_RST       = 16'd6554;
    localparam logic [15:0] GAIN_ONE       = 16'd32768;
    localparam logic [31:0] STEP_MAX       = 32'h8000_0000;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_TARGET_GAIN = 2'd1,
        CFG_ALPHA       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [15:0] target_gain;
        logic [15:0] alpha;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               block_end;
    } t_result;

    typedef logic [SINE_LEN-1:0][15:0] t_sine_tab;
    typedef logic [TANH_LEN-1:0][15:0] t_tanh_tab;

    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], a[j]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] sine_entry(int unsigned k);
        logic [63:0] kk;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] v;
        kk = 64'(k);
        x  = (HALF_PI_Q30 * (2 * kk + 64'd1)) >> (SINE_ADDR_BITS + 1);
        x2 = (x * x) >> 30;
        r  = Q30_ONE;
        for (int n = 0; n < 5; n++) begin
            t = (x2 * r) >> 30;
            case (n)
                0:       t = t / 64'd110;
                1:       t = t / 64'd72;
                2:       t = t / 64'd42;
                3:       t = t / 64'd20;
                default: t = t / 64'd6;
            endcase
            r = (t < Q30_ONE) ? (Q30_ONE - t) : 64'd0;
        end
        r = (x * r) >> 30;
        v = (r * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        return v[15:0];
    endfunction

    function automatic logic [15:0] tanh_entry(int unsigned i);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] v;
        y    = (64'(i) << 31) >> TANH_ADDR_BITS;
        term = Q30_ONE;
        e    = Q30_ONE;
        for (int n = 1; n <= 25; n++) begin
            term = udiv64((term * y) >> 30, 64'(n));
            e    = e + term;
        end
        num = (e - Q30_ONE) << 15;
        den = e + Q30_ONE;
        v   = udiv64(2 * num + den, 2 * den);
        return v[15:0];
    endfunction

    function automatic t_sine_tab sogs_build_sine();
        t_sine_tab tab;
        for (int k = 0; k < SINE_LEN; k++) begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

    function automatic t_tanh_tab sogs_build_tanh();
        t_tanh_tab tab;
        for (int k = 0; k < TANH_LEN; k++) begin
            tab[k] = tanh_entry(k);
        end
        return tab;
    endfunction

endpackage

FILE: rtl/core/sogs_if.sv
interface sogs_in_if;
    logic valid;
    logic ready;
    logic block_end;

    modport source (output valid, output block_end, input ready);
    modport sink   (input valid, input block_end, output ready);
endinterface

interface sogs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               block_end_out;

    modport source (output valid, output left_sample, output right_sample,
                    output block_end_out, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input block_end_out, output ready);
endinterface

interface sogs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sogs_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/sine_oscillator_gain_smoothing.sv
// An accepted frame steps the sequencer through GAIN, PROD, TI, LO, HI, MIX
// and DONE, then its result enters the output register; a new frame is taken
// only once the result is handed on. The shared multiplier is used three times
// per frame and both table reads are registered. Reset (synchronous, active
// low): phase 0, gain 6554, registers to defaults, output register empty.
module sine_oscillator_gain_smoothing (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sogs_cfg_if.sink   i_cfg,
    sogs_in_if.sink    i_in,
    sogs_out_if.source o_out
);
    import sogs_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step  <= PHASE_STEP_RST;
            r_cfg.target_gain <= TARGET_RST;
            r_cfg.alpha       <= ALPHA_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_PHASE_STEP:  r_cfg.phase_step  <= i_cfg.data;
                CFG_TARGET_GAIN: r_cfg.target_gain <= i_cfg.data[15:0];
                CFG_ALPHA:       r_cfg.alpha       <= i_cfg.data[15:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    sogs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_in.valid),
        .o_req_ready (i_in.ready),
        .i_block_end (i_in.block_end),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.left_sample   = r_out.sample;
    assign o_out.right_sample  = r_out.sample;
    assign o_out.block_end_out = r_out.block_end;

endmodule

FILE: rtl/core/sogs_mul.sv
module sogs_mul (
    input  logic                                 i_clk,
    input  logic signed [sogs_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [sogs_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [sogs_pkg::MUL_P_W-1:0]  o_p
);
    import sogs_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: rtl/core/sogs_core.sv
module sogs_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sogs_pkg::t_cfg    i_cfg,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic              i_block_end,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output sogs_pkg::t_result o_res
);
    import sogs_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_GAIN = 8'b0000_0010,
        ST_PROD = 8'b0000_0100,
        ST_TI   = 8'b0000_1000,
        ST_LO   = 8'b0001_0000,
        ST_HI   = 8'b0010_0000,
        ST_MIX  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    localparam t_sine_tab SINE_TAB = sogs_build_sine();
    localparam t_tanh_tab TANH_TAB = sogs_build_tanh();

    t_state r_state, n_state;

    logic [31:0]               r_phase;
    logic [15:0]               r_gain;
    logic [15:0]               r_smag;
    logic                      r_neg;
    logic                      r_block_end;
    logic [TANH_ADDR_BITS-1:0] r_ti;
    logic [TANH_FB-1:0]        r_frac;
    logic [15:0]               r_tq;
    logic [15:0]               r_lo;
    t_result                   r_res;

    logic                      w_accept;
    logic [31:0]               w_step;
    logic [15:0]               w_tgt;
    logic signed [16:0]        w_diff;
    logic [1:0]                w_quad;
    logic [SINE_ADDR_BITS-1:0] w_sidx;
    logic signed [MUL_A_W-1:0] w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic signed [MUL_P_W-1:0] w_mp;
    logic signed [MUL_P_W-1:0] w_gsum;
    logic signed [MUL_P_W-1:0] w_gshift;
    logic signed [18:0]        w_gnew;
    logic [15:0]               w_gclip;
    logic [TANH_ADDR_BITS:0]   w_taddr;
    logic [15:0]               w_hl;
    logic [MUL_P_W-1:0]        w_irnd;
    logic [17:0]               w_mag;
    logic [14:0]               w_magc;
    logic [15:0]               w_sample;

    assign w_accept = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == ST_IDLE);

    always_comb begin
        w_step = i_cfg.phase_step;
        if (w_step == 32'd0) begin
            w_step = 32'd1;
        end else if (w_step > STEP_MAX) begin
            w_step = STEP_MAX;
        end
        w_tgt = (i_cfg.target_gain > GAIN_ONE) ? GAIN_ONE : i_cfg.target_gain;
    end

    assign w_diff = $signed({1'b0, w_tgt}) - $signed({1'b0, r_gain});
    assign w_quad = r_phase[31:30];
    assign w_sidx = w_quad[0] ? ~r_phase[29 -: SINE_ADDR_BITS]
                              : r_phase[29 -: SINE_ADDR_BITS];
    assign w_hl   = (r_tq >= r_lo) ? (r_tq - r_lo) : 16'd0;

    always_comb begin
        case (r_state)
            ST_PROD: begin
                w_ma = $signed({{(MUL_A_W-16){1'b0}}, r_smag});
                w_mb = $signed({{(MUL_B_W-16){1'b0}}, r_gain});
            end
            ST_HI: begin
                w_ma = $signed({{(MUL_A_W-16){1'b0}}, w_hl});
                w_mb = $signed({{(MUL_B_W-TANH_FB){1'b0}}, r_frac});
            end
            default: begin
                w_ma = MUL_A_W'(w_diff);
                w_mb = $signed({{(MUL_B_W-16){1'b0}}, i_cfg.alpha});
            end
        endcase
    end

    sogs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_mp)
    );

    always_comb begin
        w_gsum   = w_mp + $signed({{(MUL_P_W-17){1'b0}}, 17'd32768});
        w_gshift = w_gsum >>> 16;
        w_gnew   = $signed({3'b000, r_gain}) + $signed(w_gshift[18:0]);
        if (w_gnew < 0) begin
            w_gclip = 16'd0;
        end else if (w_gnew > $signed({3'b000, GAIN_ONE})) begin
            w_gclip = GAIN_ONE;
        end else begin
            w_gclip = w_gnew[15:0];
        end
    end

    assign w_taddr = (r_state == ST_TI) ? {1'b0, w_mp[29:TANH_FB]}
                                        : ({1'b0, r_ti} + 1'b1);

    always_comb begin
        w_irnd = w_mp + (MUL_P_W'(1) << (TANH_FB - 1));
        w_mag  = {2'b00, r_lo} + {1'b0, w_irnd[TANH_FB +: 17]};
        w_magc = (w_mag > 18'd32767) ? 15'h7fff : w_mag[14:0];
        w_sample = r_neg ? (16'd0 - {1'b0, w_magc}) : {1'b0, w_magc};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_req_valid) n_state = ST_GAIN;
            ST_GAIN: n_state = ST_PROD;
            ST_PROD: n_state = ST_TI;
            ST_TI:   n_state = ST_LO;
            ST_LO:   n_state = ST_HI;
            ST_HI:   n_state = ST_MIX;
            ST_MIX:  n_state = ST_DONE;
            ST_DONE: if (i_res_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_gain  <= GAIN_RST;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_phase <= r_phase + w_step;
            end
            if (r_state == ST_GAIN) begin
                r_gain <= w_gclip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smag      <= SINE_TAB[w_sidx];
            r_neg       <= w_quad[1];
            r_block_end <= i_block_end;
        end
        if (r_state == ST_TI) begin
            r_ti   <= w_mp[29:TANH_FB];
            r_frac <= w_mp[TANH_FB-1:0];
        end
        if (r_state == ST_LO) begin
            r_lo <= r_tq;
        end
        r_tq <= TANH_TAB[w_taddr];
        if (r_state == ST_MIX) begin
            r_res.sample    <= $signed(w_sample);
            r_res.block_end <= r_block_end;
        end
    end

    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_GAIN))
        else $error("accepted transaction did not start gain update");
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_GAIN) |=> (r_gain <= GAIN_ONE))
        else $error("smoothed gain above unity");
    a_phase_hold: assert property (@(posedge i_clk)
        (i_rst_n && !w_accept) |=> $stable(r_phase))
        else $error("phase moved without a transaction");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import sogs_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RST_CYCLES    = 12;
    localparam int RANDOM_FRAMES = 500;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int GAIN_FULL     = 32768;
    localparam int FRAC_BITS     = 30 - TANH_ADDR_BITS;
    localparam int SINE_ENTRIES  = 1 << SINE_ADDR_BITS;
    localparam int TANH_ENTRIES  = (1 << TANH_ADDR_BITS) + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [31:0] STEP_CAP     = 32'h8000_0000;
    localparam logic [63:0] Q30          = 64'd1 << 30;
    localparam logic [63:0] QUARTER_TURN = 64'd1686629713;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               block_end;
    } t_frame;

    class sample_scoreboard;
        logic [15:0] sine_rom [SINE_ENTRIES];
        logic [15:0] tanh_rom [TANH_ENTRIES];
        logic [31:0] step_reg;
        logic [31:0] target_reg;
        logic [31:0] alpha_reg;
        logic [31:0] phase_acc;
        int          gain_now;
        t_frame      pending_frames [$];
        int          checked;
        int          ends_seen;
        int          errors;

        function new();
            for (int k = 0; k < SINE_ENTRIES; k++) sine_rom[k] = quarter_sine(k);
            for (int k = 0; k < TANH_ENTRIES; k++) tanh_rom[k] = tanh_q15(k);
            step_reg   = PHASE_STEP_RST;
            target_reg = {16'd0, TARGET_RST};
            alpha_reg  = {16'd0, ALPHA_RST};
            phase_acc  = '0;
            gain_now   = int'(GAIN_RST);
            checked    = 0;
            ends_seen  = 0;
            errors     = 0;
        endfunction

        // sin(pi/2 * (k + 0.5) / N) in Q1.15, Taylor series in Q30
        function logic [15:0] quarter_sine(int unsigned k);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] r;
            logic [63:0] t;
            logic [63:0] v;
            logic [63:0] divs [5];
            divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
            x  = (QUARTER_TURN * (64'(k) * 2 + 1)) / (64'd2 << SINE_ADDR_BITS);
            x2 = (x * x) >> 30;
            r  = Q30;
            for (int n = 0; n < 5; n++) begin
                t = ((x2 * r) >> 30) / divs[n];
                r = (t < Q30) ? Q30 - t : 64'd0;
            end
            r = (x * r) >> 30;
            v = (r * 64'd32767 + (Q30 >> 1)) >> 30;
            return v[15:0];
        endfunction

        // tanh(i / 2^TANH_ADDR_BITS) * 32768 via exp(2x) in Q30
        function logic [15:0] tanh_q15(int unsigned i);
            logic [63:0] y;
            logic [63:0] term;
            logic [63:0] e;
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] v;
            y    = (64'(i) << 31) >> TANH_ADDR_BITS;
            term = Q30;
            e    = Q30;
            for (int n = 1; n <= 25; n++) begin
                term = ((term * y) >> 30) / 64'(n);
                e    = e + term;
            end
            num = (e - Q30) << 15;
            den = e + Q30;
            v   = (2 * num + den) / (2 * den);
            return v[15:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_PHASE_STEP:  step_reg   = data;
                CFG_TARGET_GAIN: target_reg = {16'd0, data[15:0]};
                CFG_ALPHA:       alpha_reg  = {16'd0, data[15:0]};
                default: ;
            endcase
        endfunction

        function void predict_frame(logic be);
            logic [31:0]               step;
            logic [63:0]               prod;
            logic [63:0]               frac;
            logic [63:0]               lo;
            logic [63:0]               hi;
            logic [63:0]               span;
            logic [63:0]               mag;
            logic [SINE_ADDR_BITS-1:0] idx;
            logic [15:0]               sample;
            longint                    diff;
            longint                    g;
            int unsigned               tgt;
            int unsigned               ti;
            t_frame                    f;
            step = step_reg;
            if (step == 32'd0) step = 32'd1;
            else if (step > STEP_CAP) step = STEP_CAP;
            tgt = (target_reg > GAIN_FULL) ? GAIN_FULL : target_reg;

            // smoothed gain, round half up
            diff = longint'(tgt) - longint'(gain_now);
            g = longint'(gain_now) + ((diff * longint'(alpha_reg) + 32768) >>> 16);
            if (g < 0) g = 0;
            if (g > GAIN_FULL) g = GAIN_FULL;
            gain_now = int'(g);

            idx = phase_acc[29 -: SINE_ADDR_BITS];
            if (phase_acc[30]) idx = ~idx;
            prod = 64'(sine_rom[idx]) * 64'(gain_now);

            ti = int'(prod >> FRAC_BITS);
            if (ti > TANH_ENTRIES - 2) ti = TANH_ENTRIES - 2;
            frac = prod - (64'(ti) << FRAC_BITS);
            lo   = 64'(tanh_rom[ti]);
            hi   = 64'(tanh_rom[ti + 1]);
            span = (hi >= lo) ? hi - lo : 64'd0;
            mag  = lo + ((span * frac + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            if (mag > 64'd32767) mag = 64'd32767;
            sample = phase_acc[31] ? -mag[15:0] : mag[15:0];

            f.left      = sample;
            f.right     = sample;
            f.block_end = be;
            pending_frames.push_back(f);
            phase_acc = phase_acc + step;
        endfunction

        function void check_frame(logic signed [15:0] left, logic signed [15:0] right,
                                  logic be);
            t_frame f;
            if (pending_frames.size() == 0) begin
                $error("output transaction with no frame outstanding: left_sample %0d", left);
                errors++;
                return;
            end
            f = pending_frames.pop_front();
            checked++;
            if (f.block_end) ends_seen++;
            if (left !== f.left) begin
                $error("left_sample: expected %0d, actual %0d", f.left, left);
                errors++;
            end
            if (right !== f.right) begin
                $error("right_sample: expected %0d, actual %0d", f.right, right);
                errors++;
            end
            if (be !== f.block_end) begin
                $error("block_end_out: expected %0b, actual %0b", f.block_end, be);
                errors++;
            end
        endfunction

        function int pending();
            return pending_frames.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sogs_cfg_if cfg_bus ();
    sogs_in_if  in_bus ();
    sogs_out_if out_bus ();

    sine_oscillator_gain_smoothing uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    sample_scoreboard sb = new();

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_wanted  = 1'b0;
    int frames_sent  = 0;
    int reg_writes   = 0;

    always #CLK_HALF i_clk = ~i_clk;

    // output ready, with one long hold-off on request
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            sb.check_frame(out_bus.left_sample, out_bus.right_sample, out_bus.block_end_out);
        end
    end

    task automatic send_frame(input logic be);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.block_end <= be;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.predict_frame(be);
        frames_sent++;
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.write_reg(idx, data);
        reg_writes++;
    endtask

    task automatic configure(input logic [31:0] step, input logic [31:0] target,
                             input logic [31:0] alpha, input bit poke_unused);
        drain();
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_TARGET_GAIN, target);
        write_reg(CFG_ALPHA, alpha);
        if (poke_unused) write_reg(CFG_UNUSED, $urandom());
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        int          sent;
        int          n;
        logic [31:0] step_w;
        logic [31:0] target_w;
        logic [31:0] alpha_w;

        i_rst_n          <= 1'b0;
        in_bus.valid     <= 1'b0;
        in_bus.block_end <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_PHASE_STEP;
        cfg_bus.data     <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 25;
        snk_idle_pct = 66;

        // power-on settings
        send_frame(1'b0);
        send_frame(1'b1);
        send_frame(1'b0);

        // quarter-turn steps walk the quadrants, fastest smoothing to full gain
        configure(32'h4000_0000, GAIN_FULL, 32'd65535, 1'b0);
        repeat (5) send_frame($urandom_range(0, 1));

        // tuning word above Nyquist, target above 1.0, frozen gain
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
        repeat (3) send_frame($urandom_range(0, 1));

        // zero tuning word, fade to silence
        configure(32'd0, 32'd0, 32'd65535, 1'b1);
        repeat (3) send_frame($urandom_range(0, 1));

        // exactly Nyquist, half-step smoothing
        configure(STEP_CAP, GAIN_FULL, 32'd32768, 1'b0);
        repeat (3) send_frame($urandom_range(0, 1));

        // lands near the quadrant edges at full gain
        configure(32'h3FF0_0000, GAIN_FULL, 32'd65535, 1'b0);
        repeat (4) send_frame($urandom_range(0, 1));

        for (int m = 0; m < 3; m++) begin
            src_idle_pct = (m == 0) ? 25 : (m == 1) ? 66 : 0;
            snk_idle_pct = (m == 0) ? 66 : (m == 1) ? 25 : 0;
            sent = 0;
            while (sent < RANDOM_FRAMES / 3) begin
                case ($urandom_range(0, 9))
                    0:       step_w = 32'd0;
                    1:       step_w = STEP_CAP;
                    2:       step_w = STEP_CAP | $urandom();
                    3, 4:    step_w = $urandom_range(1, 32'h0010_0000);
                    default: step_w = $urandom();
                endcase
                case ($urandom_range(0, 7))
                    0:       target_w = 32'd0;
                    1:       target_w = GAIN_FULL;
                    2:       target_w = $urandom();
                    default: target_w = $urandom_range(0, GAIN_FULL);
                endcase
                case ($urandom_range(0, 7))
                    0:       alpha_w = 32'd0;
                    1:       alpha_w = 32'd65535;
                    2:       alpha_w = $urandom();
                    default: alpha_w = $urandom_range(0, 65535);
                endcase
                configure(step_w, target_w, alpha_w, $urandom_range(0, 4) == 0);
                if (m == 2) hold_wanted = 1'b1;
                n = $urandom_range(12, 40);
                repeat (n) send_frame($urandom_range(0, 1));
                sent += n;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d of %0d frames (%0d buffer ends) across %0d register writes,",
                 sb.checked, frames_sent, sb.ends_seen, reg_writes);
        $display("with clipped tuning words and targets, gain extremes and a long output stall.");
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
